>>> rtl/stp_pkg.sv
// shared types, constants and lookup functions for the half-step stepper sequencer
package stp_pkg;

    // field widths
    localparam int ANGLE_W = 16;
    localparam int RPM_W   = 8;
    localparam int PHASE_W = 4;
    localparam int INDEX_W = 3;
    localparam int COILS_W = 4;

    // default and range of the degrees-per-sequence setting
    localparam int DEGREES_PER_SEQUENCE_DEF = 1;
    localparam int DEGREES_PER_SEQUENCE_MAX = 360;

    // phase time limits in milliseconds
    localparam logic [PHASE_W-1:0] PHASE_MS_STOPPED = 4'd15;
    localparam logic [PHASE_W-1:0] PHASE_MS_FAST    = 4'd1;
    localparam logic [RPM_W-1:0]   RPM_FAST_LIMIT   = 8'd14;

    // last pattern of one sequence
    localparam logic [INDEX_W-1:0] LAST_PHASE = 3'd7;

    // item codes
    typedef enum logic {
        ACT_TICK  = 1'b0,
        ACT_START = 1'b1
    } stp_action_t;

    // one input item
    typedef struct packed {
        stp_action_t            action;
        logic [ANGLE_W-1:0]     angle;
        logic                   direction;
        logic [RPM_W-1:0]       rpm;
    } stp_item_t;

    // phase time from speed: floor(60000 / (4096 * rpm)) for rpm 1..14
    function automatic logic [PHASE_W-1:0] phase_time_of(input logic [RPM_W-1:0] rpm);
        logic [PHASE_W-1:0] ms;
        begin
            if (rpm == '0) begin
                ms = PHASE_MS_STOPPED;
            end else if (rpm > RPM_FAST_LIMIT) begin
                ms = PHASE_MS_FAST;
            end else begin
                case (rpm)
                    8'd1:    ms = 4'd14;
                    8'd2:    ms = 4'd7;
                    8'd3:    ms = 4'd4;
                    8'd4:    ms = 4'd3;
                    8'd5:    ms = 4'd2;
                    8'd6:    ms = 4'd2;
                    8'd7:    ms = 4'd2;
                    default: ms = PHASE_MS_FAST;
                endcase
            end
            return ms;
        end
    endfunction

    // coil pattern, bit 0 = A .. bit 3 = D
    function automatic logic [COILS_W-1:0] coil_pattern(input logic acw,
                                                       input logic [INDEX_W-1:0] idx);
        logic [COILS_W-1:0] p;
        begin
            if (acw) begin
                case (idx)
                    3'd0:    p = 4'h1;
                    3'd1:    p = 4'h3;
                    3'd2:    p = 4'h2;
                    3'd3:    p = 4'h6;
                    3'd4:    p = 4'h4;
                    3'd5:    p = 4'hC;
                    3'd6:    p = 4'h8;
                    default: p = 4'h9;
                endcase
            end else begin
                case (idx)
                    3'd0:    p = 4'h9;
                    3'd1:    p = 4'h8;
                    3'd2:    p = 4'hC;
                    3'd3:    p = 4'h4;
                    3'd4:    p = 4'h6;
                    3'd5:    p = 4'h2;
                    3'd6:    p = 4'h3;
                    default: p = 4'h1;
                endcase
            end
            return p;
        end
    endfunction

endpackage

>>> rtl/stp_in_stage.sv
// input register stage holding one accepted item
module stp_in_stage
    import stp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  stp_item_t s_item,
    input  logic      take,
    output logic      item_valid,
    output stp_item_t item
);

    logic      valid_reg;
    logic      valid_next;
    stp_item_t item_reg;

    // free when empty or when the held item moves on this cycle
    assign s_ready    = !valid_reg || take;
    assign valid_next = (s_valid && s_ready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    // valid flag and payload
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> rtl/stp_core.sv
// motion state, next-state logic and result register
module stp_core
    import stp_pkg::*;
#(
    parameter int DEGREES_PER_SEQUENCE = DEGREES_PER_SEQUENCE_DEF
)
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               item_valid,
    input  stp_item_t          item,
    output logic               take,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [COILS_W-1:0] coils,
    output logic               busy
);

    // exact division by a constant through a reciprocal multiply
    localparam int DIV_SHIFT = ANGLE_W + $clog2(DEGREES_PER_SEQUENCE);
    localparam longint unsigned DIV_MULT =
        ((64'd1 << DIV_SHIFT) + DEGREES_PER_SEQUENCE - 1) / DEGREES_PER_SEQUENCE;
    localparam int MULT_W = ANGLE_W + 1;
    localparam int PROD_W = DIV_SHIFT + ANGLE_W;

    logic [ANGLE_W-1:0] seq_left_reg,  seq_left_next;
    logic [INDEX_W-1:0] phase_idx_reg, phase_idx_next;
    logic [PHASE_W-1:0] time_left_reg, time_left_next;
    logic [PHASE_W-1:0] reload_reg,    reload_next;
    logic               acw_reg,       acw_next;
    logic               moving_reg,    moving_next;
    logic               out_valid_reg, out_valid_next;
    logic [COILS_W-1:0] coils_reg,     coils_next;
    logic               busy_reg;

    logic [MULT_W-1:0]  div_mult;
    logic [PROD_W-1:0]  div_prod;
    logic [ANGLE_W-1:0] seq_count;
    logic [PHASE_W-1:0] time_dec;
    logic [ANGLE_W-1:0] seq_dec;

    // item moves to the result register when that is free or being emptied
    assign take = item_valid && (!out_valid_reg || m_ready);

    assign div_mult  = MULT_W'(DIV_MULT);
    assign div_prod  = PROD_W'(item.angle) * PROD_W'(div_mult);
    assign seq_count = div_prod[DIV_SHIFT +: ANGLE_W];

    // next motion state for the item in the input register
    always_comb begin
        seq_left_next  = seq_left_reg;
        phase_idx_next = phase_idx_reg;
        time_left_next = time_left_reg;
        reload_next    = reload_reg;
        acw_next       = acw_reg;
        moving_next    = moving_reg;
        time_dec       = (time_left_reg != '0) ? time_left_reg - 1'b1 : time_left_reg;
        seq_dec        = (seq_left_reg != '0) ? seq_left_reg - 1'b1 : seq_left_reg;
        if (item.action == ACT_START) begin
            if (!moving_reg && seq_count != '0) begin
                seq_left_next  = seq_count;
                phase_idx_next = '0;
                reload_next    = phase_time_of(item.rpm);
                time_left_next = phase_time_of(item.rpm);
                acw_next       = item.direction;
                moving_next    = 1'b1;
            end
        end else if (moving_reg) begin
            time_left_next = time_dec;
            if (time_dec == '0) begin
                time_left_next = reload_reg;
                if (phase_idx_reg == LAST_PHASE) begin
                    phase_idx_next = '0;
                    seq_left_next  = seq_dec;
                    if (seq_dec == '0) begin
                        moving_next    = 1'b0;
                        time_left_next = '0;
                    end
                end else begin
                    phase_idx_next = phase_idx_reg + 1'b1;
                end
            end
        end
        coils_next = moving_next ? coil_pattern(acw_next, phase_idx_next) : '0;
    end

    assign out_valid_next = take ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);

    // state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_left_reg  <= '0;
            phase_idx_reg <= '0;
            time_left_reg <= '0;
            reload_reg    <= '0;
            acw_reg       <= 1'b0;
            moving_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (take) begin
                seq_left_reg  <= seq_left_next;
                phase_idx_reg <= phase_idx_next;
                time_left_reg <= time_left_next;
                reload_reg    <= reload_next;
                acw_reg       <= acw_next;
                moving_reg    <= moving_next;
            end
        end
        if (take) begin
            coils_reg <= coils_next;
            busy_reg  <= moving_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign coils   = coils_reg;
    assign busy    = busy_reg;

endmodule

>>> rtl/stepper_half_step_sequencer.sv
// top level of the four-coil half-step stepper sequencer
//
// Input channel (s_valid/s_ready): each item is either a 1 ms tick
// (s_action = 0) or a start command (s_action = 1) carrying angle,
// direction and rpm. A start is taken only while idle; a start during a
// move is ignored but still answered. The sequence count is angle divided
// by DEGREES_PER_SEQUENCE; each sequence steps through eight half-step
// coil patterns, each held for a phase time in ms set by the speed.
// Result channel (m_valid/m_ready): one item per input item, giving the
// coil levels and the busy flag as they stand after that input item.
// The accepted item sits in the input register, then passes the next-state
// logic into the result register once that is free. Throughput is one item
// per cycle while m_ready stays high; the motion state is updated once per
// item in a single pass, so consecutive items never wait on each other.
// When the receiver stalls, the result register holds and the input
// register still takes one more item; s_ready drops once both are full.
// Synchronous active-low reset leaves the block idle and both registers
// empty; the coil levels and busy flag of the result are not reset.
module stepper_half_step_sequencer
    import stp_pkg::*;
#(
    parameter int DEGREES_PER_SEQUENCE = DEGREES_PER_SEQUENCE_DEF
)
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_action,
    input  logic [ANGLE_W-1:0] s_angle,
    input  logic               s_direction,
    input  logic [RPM_W-1:0]   s_rpm,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_coil_a,
    output logic               m_coil_b,
    output logic               m_coil_c,
    output logic               m_coil_d,
    output logic               m_busy_res
);

    stp_item_t          s_item;
    stp_item_t          item;
    logic               item_valid;
    logic               take;
    logic [COILS_W-1:0] coils;

    // pack the input fields
    assign s_item.action    = stp_action_t'(s_action);
    assign s_item.angle     = s_angle;
    assign s_item.direction = s_direction;
    assign s_item.rpm       = s_rpm;

    stp_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    stp_core #(
        .DEGREES_PER_SEQUENCE (DEGREES_PER_SEQUENCE)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .coils      (coils),
        .busy       (m_busy_res)
    );

    // unpack the coil levels
    assign m_coil_a = coils[0];
    assign m_coil_b = coils[1];
    assign m_coil_c = coils[2];
    assign m_coil_d = coils[3];

endmodule

>>> rtl/stp_checker.sv
// port-level checks for the stepper sequencer, bound to the top level
module stp_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_coil_a,
    input logic m_coil_b,
    input logic m_coil_c,
    input logic m_coil_d,
    input logic m_busy_res
);

    // idle results drive no coil
    a_idle_coils_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_busy_res) |-> !(m_coil_a || m_coil_b || m_coil_c || m_coil_d))
        else $error("coil driven while idle");

    // a half-step pattern has one or two adjacent coils on
    a_busy_pattern: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_busy_res) |->
            ($countones({m_coil_d, m_coil_c, m_coil_b, m_coil_a}) == 1 ||
             $countones({m_coil_d, m_coil_c, m_coil_b, m_coil_a}) == 2))
        else $error("bad coil pattern while busy");

    // no result appears the cycle after reset releases
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

    // stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable({m_coil_a, m_coil_b, m_coil_c,
                                                         m_coil_d, m_busy_res})))
        else $error("stalled result changed");

    // input side only blocks while a result waits on the receiver
    a_ready_low_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input blocked without a stalled result");

endmodule

bind stepper_half_step_sequencer stp_checker u_stp_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_coil_a   (m_coil_a),
    .m_coil_b   (m_coil_b),
    .m_coil_c   (m_coil_c),
    .m_coil_d   (m_coil_d),
    .m_busy_res (m_busy_res)
);

>>> bench/stepper_half_step_sequencer_tb.sv
// self-checking testbench for the half-step stepper sequencer
module stepper_half_step_sequencer_tb;
    import stp_pkg::*;

    localparam int DEG_PER_SEQ = DEGREES_PER_SEQUENCE_DEF;
    localparam int RANDOM_ITEMS_END = 1650;
    localparam int CYCLE_LIMIT = 200000;

    // one result item: busy flag over coils, bit 0 = A .. bit 3 = D
    typedef struct packed {
        logic               busy;
        logic [COILS_W-1:0] coils;
    } coil_result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_action = 1'b0;
    logic [ANGLE_W-1:0] s_angle = '0;
    logic               s_direction = 1'b0;
    logic [RPM_W-1:0]   s_rpm = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_coil_a;
    logic               m_coil_b;
    logic               m_coil_c;
    logic               m_coil_d;
    logic               m_busy_res;

    // motor state as predicted from the accepted items
    logic [ANGLE_W-1:0] seq_left = '0;
    logic [INDEX_W-1:0] phase_idx = '0;
    logic [PHASE_W-1:0] hold_left = '0;
    logic [PHASE_W-1:0] hold_reload = '0;
    logic               acw = 1'b0;
    logic               motor_on = 1'b0;

    coil_result_t expected_coils[$];
    coil_result_t want_res;
    int           fail_count = 0;
    int           items_sent = 0;
    int           cycles = 0;
    bit           steady = 1'b0;

    stepper_half_step_sequencer #(
        .DEGREES_PER_SEQUENCE(DEG_PER_SEQ)
    ) uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_angle     (s_angle),
        .s_direction (s_direction),
        .s_rpm       (s_rpm),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_coil_a    (m_coil_a),
        .m_coil_b    (m_coil_b),
        .m_coil_c    (m_coil_c),
        .m_coil_d    (m_coil_d),
        .m_busy_res  (m_busy_res)
    );

    always #5 aclk = ~aclk;

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // hold time in ms for a given speed
    function automatic logic [PHASE_W-1:0] hold_ms(input logic [RPM_W-1:0] spd);
        begin
            if (spd == '0) begin
                return PHASE_MS_STOPPED;
            end else if (spd > RPM_FAST_LIMIT) begin
                return PHASE_MS_FAST;
            end
            return PHASE_W'(60000 / (4096 * int'(spd)));
        end
    endfunction

    // step the predicted motor state by one item and queue the coils it leaves
    task automatic advance_motor(input stp_action_t act, input logic [ANGLE_W-1:0] ang,
                                 input logic dir, input logic [RPM_W-1:0] spd);
        logic [INDEX_W-1:0] k;
        logic [1:0]         c;
        logic [COILS_W-1:0] p;
        coil_result_t       r;
        begin
            if (act == ACT_START) begin
                if (!motor_on && (ang / DEG_PER_SEQ) != 0) begin
                    seq_left    = ANGLE_W'(ang / DEG_PER_SEQ);
                    phase_idx   = '0;
                    hold_reload = hold_ms(spd);
                    hold_left   = hold_reload;
                    acw         = dir;
                    motor_on    = 1'b1;
                end
            end else if (motor_on) begin
                if (hold_left != 0) hold_left--;
                if (hold_left == 0) begin
                    hold_left = hold_reload;
                    if (phase_idx == LAST_PHASE) begin
                        phase_idx = '0;
                        if (seq_left != 0) seq_left--;
                        // last sequence done: coils off, idle
                        if (seq_left == 0) begin
                            motor_on  = 1'b0;
                            hold_left = '0;
                        end
                    end else begin
                        phase_idx++;
                    end
                end
            end
            // clockwise walks the anticlockwise order backwards;
            // even steps drive one coil, odd steps that coil and the next
            p = '0;
            if (motor_on) begin
                k = acw ? phase_idx : LAST_PHASE - phase_idx;
                c = k[2:1];
                p = 4'b0001 << c;
                if (k[0]) p = p | (4'b0001 << (c + 2'd1));
            end
            r.busy  = motor_on;
            r.coils = p;
            expected_coils.push_back(r);
        end
    endtask

    // offer one item, idling at random beforehand unless steady, and predict it once taken
    task automatic send_item(input stp_action_t act, input logic [ANGLE_W-1:0] ang,
                             input logic dir, input logic [RPM_W-1:0] spd);
        begin
            if (!steady) begin
                while ($urandom_range(0, 99) < 33) begin
                    s_valid <= 1'b0;
                    @(posedge aclk);
                end
            end
            s_valid     <= 1'b1;
            s_action    <= act;
            s_angle     <= ang;
            s_direction <= dir;
            s_rpm       <= spd;
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
            advance_motor(act, ang, dir, spd);
            items_sent++;
        end
    endtask

    // tick until the move ends, with the odd start thrown in while busy
    task automatic finish_move();
        begin
            while (motor_on) begin
                if ($urandom_range(0, 99) < 5) begin
                    send_item(ACT_START, ANGLE_W'($urandom_range(0, 65535)),
                              1'($urandom_range(0, 1)), RPM_W'($urandom_range(0, 255)));
                end else begin
                    send_item(ACT_TICK, ANGLE_W'($urandom_range(0, 65535)),
                              1'($urandom_range(0, 1)), RPM_W'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    // ticks while idle and a start too short for one sequence
    task automatic test_idle_and_empty_starts();
        begin
            send_item(ACT_TICK, '0, 1'b0, '0);
            send_item(ACT_START, '0, 1'b1, 8'hFF);
            send_item(ACT_TICK, 16'hFFFF, 1'b1, 8'hFF);
        end
    endtask

    // one anticlockwise sequence with a start ignored mid-move
    task automatic test_single_sequence();
        begin
            send_item(ACT_START, ANGLE_W'(DEG_PER_SEQ), 1'b1, 8'hFF);
            repeat (3) send_item(ACT_TICK, '0, 1'b0, '0);
            send_item(ACT_START, 16'hFFFF, 1'b0, 8'h00);
            while (motor_on) send_item(ACT_TICK, '0, 1'b0, '0);
            send_item(ACT_TICK, '0, 1'b0, '0);
        end
    endtask

    // two clockwise sequences back to back, fed without gaps after a drain
    task automatic test_back_to_back_sequences();
        begin
            s_valid <= 1'b0;
            while (expected_coils.size() != 0) @(posedge aclk);
            steady = 1'b1;
            send_item(ACT_START, ANGLE_W'(2 * DEG_PER_SEQ), 1'b0, RPM_FAST_LIMIT + 8'd1);
            while (motor_on) send_item(ACT_TICK, '0, 1'b0, '0);
            steady = 1'b0;
        end
    endtask

    // random moves of a few sequences, with idle noise in between
    task automatic test_random_moves();
        int                 pick;
        int                 seqs;
        logic [RPM_W-1:0]   spd;
        logic [ANGLE_W-1:0] ang;
        stp_action_t        act;
        begin
            while (items_sent < RANDOM_ITEMS_END) begin
                steady = (items_sent >= 700 && items_sent < 1000);
                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    // idle tick or a start that covers no whole sequence
                    act = (pick < 5) ? ACT_TICK : ACT_START;
                    ang = ANGLE_W'($urandom_range(0, DEG_PER_SEQ - 1));
                    send_item(act, ang, 1'($urandom_range(0, 1)),
                              RPM_W'($urandom_range(0, 255)));
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 60) begin
                        spd = RPM_W'($urandom_range(15, 255));
                    end else if (pick < 85) begin
                        spd = RPM_W'($urandom_range(1, 14));
                    end else begin
                        spd = '0;
                    end
                    // slow speeds get a single sequence to keep the run short
                    seqs = (hold_ms(spd) >= 4) ? 1 : $urandom_range(1, 3);
                    ang = ANGLE_W'(seqs * DEG_PER_SEQ + $urandom_range(0, DEG_PER_SEQ - 1));
                    send_item(ACT_START, ang, 1'($urandom_range(0, 1)), spd);
                    finish_move();
                end
            end
            steady = 1'b0;
        end
    endtask

    // result side: random back-pressure and comparison against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_coils.size() == 0) begin
                $error("result item with no expectation waiting");
                fail_count++;
            end else begin
                want_res = expected_coils.pop_front();
                if (m_coil_a !== want_res.coils[0]) begin
                    $error("coil_a: expected %0d, got %0d", want_res.coils[0], m_coil_a);
                    fail_count++;
                end
                if (m_coil_b !== want_res.coils[1]) begin
                    $error("coil_b: expected %0d, got %0d", want_res.coils[1], m_coil_b);
                    fail_count++;
                end
                if (m_coil_c !== want_res.coils[2]) begin
                    $error("coil_c: expected %0d, got %0d", want_res.coils[2], m_coil_c);
                    fail_count++;
                end
                if (m_coil_d !== want_res.coils[3]) begin
                    $error("coil_d: expected %0d, got %0d", want_res.coils[3], m_coil_d);
                    fail_count++;
                end
                if (m_busy_res !== want_res.busy) begin
                    $error("busy_res: expected %0d, got %0d", want_res.busy, m_busy_res);
                    fail_count++;
                end
            end
        end
        m_ready <= steady || ($urandom_range(0, 99) >= 33);
    end

    // test sequence
    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_idle_and_empty_starts();
        test_single_sequence();
        test_back_to_back_sequences();
        test_random_moves();
        s_valid <= 1'b0;
        while (expected_coils.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
